// File: rtl/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// shared types, field widths and defaults for the deadline trigger table
// ----------------------------------------------------------------------------
package dtt_pkg;

   localparam int NUM_SLOTS_DEF   = 16;
   localparam int TIME_WIDTH_DEF  = 48;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int OP_W         = 2;
   localparam int SLOT_W       = 4;
   localparam int DELAY_W      = 32;
   localparam int KIND_W       = 2;
   localparam int SLOT_LIMIT_W = 7;

   typedef enum logic [OP_W-1:0] {
      OP_ARM    = 2'd0,
      OP_DISARM = 2'd1,
      OP_TICK   = 2'd2
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      CMD_ARM    = 2'd0,
      CMD_DISARM = 2'd1,
      CMD_TICK   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_FLUSH = 2'd2
   } state_type;

endpackage

// File: rtl/dtt_req_if.sv
// ----------------------------------------------------------------------------
// dtt_req_if
// command channel: arm, disarm or tick, valid/ready handshake
// ----------------------------------------------------------------------------
interface dtt_req_if;
   import dtt_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    opcode;
   logic [SLOT_W-1:0]  slot_index;
   logic [DELAY_W-1:0] delay_ticks;

   modport source (output valid, opcode, slot_index, delay_ticks, input ready);
   modport sink   (input valid, opcode, slot_index, delay_ticks, output ready);
endinterface

// File: rtl/dtt_rsp_if.sv
// ----------------------------------------------------------------------------
// dtt_rsp_if
// fired slot channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface dtt_rsp_if;
   import dtt_pkg::*;

   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] fired_slot;
   logic              last_fired;

   modport source (output valid, fired_slot, last_fired, input ready);
   modport sink   (input valid, fired_slot, last_fired, output ready);
endinterface

// File: rtl/dtt_ram.sv
// ----------------------------------------------------------------------------
// dtt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module dtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/dtt_queue.sv
// ----------------------------------------------------------------------------
// dtt_queue
// short command queue between front end and back end
// ----------------------------------------------------------------------------
module dtt_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   push_never_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   pop_never_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

   count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");
endmodule

// File: rtl/dtt_front.sv
// ----------------------------------------------------------------------------
// dtt_front
// accepts commands, keeps the time count, forms deadlines, drops no-ops
// ----------------------------------------------------------------------------
module dtt_front #(
   parameter int NUM_SLOTS  = dtt_pkg::NUM_SLOTS_DEF,
   parameter int TIME_WIDTH = dtt_pkg::TIME_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   dtt_req_if.sink req_chan,
   output logic                                                   push,
   output logic [dtt_pkg::KIND_W+dtt_pkg::SLOT_W+TIME_WIDTH-1:0]  push_data,
   input  logic                                                   q_full
);
   import dtt_pkg::*;

   logic [TIME_WIDTH-1:0] time_ff, time_in;
   logic [TIME_WIDTH-1:0] time_next;
   logic [TIME_WIDTH-1:0] deadline;
   logic                  accept;
   logic                  slot_ok;
   cmd_type               kind;
   logic [TIME_WIDTH-1:0] value;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;
   assign slot_ok        = SLOT_LIMIT_W'(req_chan.slot_index) < SLOT_LIMIT_W'(NUM_SLOTS);
   assign time_next      = time_ff + 1'b1;
   assign deadline       = time_ff + TIME_WIDTH'(req_chan.delay_ticks);

   always_comb begin
      push    = 1'b0;
      kind    = CMD_TICK;
      value   = time_next;
      time_in = time_ff;
      unique case (op_type'(req_chan.opcode))
         OP_ARM: begin
            kind  = CMD_ARM;
            value = deadline;
            push  = accept && slot_ok;
         end
         OP_DISARM: begin
            kind = CMD_DISARM;
            push = accept && slot_ok;
         end
         OP_TICK: begin
            push = accept;
            if (accept) begin
               time_in = time_next;
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   assign push_data = {kind, req_chan.slot_index, value};

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
      end else begin
         time_ff <= time_in;
      end
   end
endmodule

// File: rtl/dtt_back.sv
// ----------------------------------------------------------------------------
// dtt_back
// executes queued commands: deadline ram, armed bits, tick scan, result register
// ----------------------------------------------------------------------------
module dtt_back #(
   parameter int NUM_SLOTS  = dtt_pkg::NUM_SLOTS_DEF,
   parameter int TIME_WIDTH = dtt_pkg::TIME_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic                                                   q_empty,
   input  logic [dtt_pkg::KIND_W+dtt_pkg::SLOT_W+TIME_WIDTH-1:0]  q_data,
   output logic                                                   pop,
   dtt_rsp_if.source rsp_chan
);
   import dtt_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);

   cmd_type               q_kind;
   logic [SLOT_W-1:0]     q_slot;
   logic [TIME_WIDTH-1:0] q_value;

   state_type             state_ff, state_in;
   logic [NUM_SLOTS-1:0]  armed_ff, armed_in;
   logic [CNT_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [TIME_WIDTH-1:0] now_ff, now_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]      pend_slot_ff, pend_slot_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic                  rsp_last_ff;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic                  ram_re;
   logic [TIME_WIDTH-1:0] ram_rdata;

   logic                  out_free;
   logic                  fire;
   logic                  stall;
   logic                  issue;
   logic                  scan_done;
   logic                  emit;
   logic                  emit_last;

   assign q_kind    = cmd_type'(q_data[KIND_W+SLOT_W+TIME_WIDTH-1 -: KIND_W]);
   assign q_slot    = q_data[SLOT_W+TIME_WIDTH-1 -: SLOT_W];
   assign q_value   = q_data[TIME_WIDTH-1:0];
   assign ram_waddr = IDX_W'(q_slot);

   dtt_ram #(
      .WIDTH (TIME_WIDTH),
      .DEPTH (NUM_SLOTS)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (q_value),
      .rd_en   (ram_re),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign out_free  = !rsp_vld_ff || rsp_chan.ready;
   assign fire      = cmp_vld_ff && armed_ff[cmp_idx_ff] && (ram_rdata <= now_ff);
   assign stall     = fire && pend_vld_ff && !out_free;
   assign issue     = (state_ff == ST_SCAN) && (rd_cnt_ff != CNT_W'(NUM_SLOTS)) && !stall;
   assign scan_done = (rd_cnt_ff == CNT_W'(NUM_SLOTS)) && !cmp_vld_ff;
   assign ram_re    = issue;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty && q_kind == CMD_TICK) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_vld_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      ram_we       = 1'b0;
      armed_in     = armed_ff;
      rd_cnt_in    = rd_cnt_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_idx_in   = cmp_idx_ff;
      now_in       = now_ff;
      pend_vld_in  = pend_vld_ff;
      pend_slot_in = pend_slot_ff;
      emit         = 1'b0;
      emit_last    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               unique case (q_kind)
                  CMD_ARM: begin
                     ram_we              = 1'b1;
                     armed_in[ram_waddr] = 1'b1;
                  end
                  CMD_DISARM: begin
                     armed_in[ram_waddr] = 1'b0;
                  end
                  CMD_TICK: begin
                     now_in      = q_value;
                     rd_cnt_in   = '0;
                     cmp_vld_in  = 1'b0;
                     pend_vld_in = 1'b0;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               cmp_vld_in = issue;
               cmp_idx_in = rd_cnt_ff[IDX_W-1:0];
               if (issue) begin
                  rd_cnt_in = rd_cnt_ff + 1'b1;
               end
               if (fire) begin
                  armed_in[cmp_idx_ff] = 1'b0;
                  emit                 = pend_vld_ff;
                  pend_vld_in          = 1'b1;
                  pend_slot_in         = cmp_idx_ff;
               end
            end
         end
         ST_FLUSH: begin
            if (pend_vld_ff && out_free) begin
               emit        = 1'b1;
               emit_last   = 1'b1;
               pend_vld_in = 1'b0;
            end
         end
         default: begin
            pend_vld_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (emit) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         armed_ff    <= '0;
         rd_cnt_ff   <= '0;
         cmp_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         armed_ff    <= armed_in;
         rd_cnt_ff   <= rd_cnt_in;
         cmp_vld_ff  <= cmp_vld_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff   <= cmp_idx_in;
      now_ff       <= now_in;
      pend_slot_ff <= pend_slot_in;
      if (emit) begin
         rsp_slot_ff <= SLOT_W'(pend_slot_ff);
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_chan.valid      = rsp_vld_ff;
   assign rsp_chan.fired_slot = rsp_slot_ff;
   assign rsp_chan.last_fired = rsp_last_ff;

   compare_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_SCAN |-> !cmp_vld_ff)
      else $error("compare stage busy outside scan");

   stall_holds_compare: assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(cmp_idx_ff) && $stable(ram_rdata))
      else $error("compare operand moved during stall");

   emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result written over pending transfer");

   no_pending_in_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_vld_ff)
      else $error("fired slot left behind after tick");
endmodule

// File: rtl/deadline_trigger_table_core.sv
// ----------------------------------------------------------------------------
// deadline_trigger_table_core
// bank of one-shot deadline triggers driven by a tick count
// ----------------------------------------------------------------------------
// front end takes one command transfer per cycle while the 2-entry queue has room
// arm and disarm are queued, then written to the table when the idle back end pops them
// a tick holds the back end to scan every slot, one slot per cycle while rsp has room
// first result of a tick goes through queue, ram read, compare and pending registers
// synchronous reset clears time count, armed bits, queue and result register;
// deadline ram is not cleared, entries are read on every scan but used only while their slot is armed
module deadline_trigger_table_core #(
   parameter int NUM_SLOTS  = dtt_pkg::NUM_SLOTS_DEF,
   parameter int TIME_WIDTH = dtt_pkg::TIME_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   dtt_req_if.sink   req_chan,
   dtt_rsp_if.source rsp_chan
);
   import dtt_pkg::*;

   localparam int ENTRY_W = KIND_W + SLOT_W + TIME_WIDTH;

   logic               push;
   logic [ENTRY_W-1:0] push_data;
   logic               q_full;
   logic               pop;
   logic [ENTRY_W-1:0] pop_data;
   logic               q_empty;

   dtt_front #(
      .NUM_SLOTS  (NUM_SLOTS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   dtt_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH_DEF)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   dtt_back #(
      .NUM_SLOTS  (NUM_SLOTS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (pop_data),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );
endmodule

// File: verif/tb_deadline_trigger_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deadline_trigger_table_core
// Drives arm, disarm and tick commands into the trigger table and tracks its
// own copy of time, deadlines and armed bits. Each tick's fired slots are
// queued in ascending order with the last flagged. Every fired-slot transfer
// is then checked against that queue. A directed table comes first, then
// random arm/tick sequences, table fills and noise under three idle mixes.
// ----------------------------------------------------------------------------
module tb_deadline_trigger_table_core;
   import dtt_pkg::*;

   localparam int SLOTS       = NUM_SLOTS_DEF;
   localparam int TIME_W      = TIME_WIDTH_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 40;
   localparam int N_DIRECTED  = 25;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              last;
   } fire_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [SLOT_W-1:0]  slot;
      logic [DELAY_W-1:0] delay;
      logic               typed;
      logic [SLOTS-1:0]   fires;
   } dir_row_type;

   localparam dir_row_type DIRECTED [N_DIRECTED] = '{
      '{OP_TICK,   4'd0,  32'd0,          1'b1, 16'h0000},
      '{OP_DISARM, 4'd3,  32'd0,          1'b1, 16'h0000},
      '{OP_UNUSED, 4'd15, 32'hFFFF_FFFF,  1'b1, 16'h0000},
      '{OP_ARM,    4'd0,  32'd0,          1'b1, 16'h0000},
      '{OP_ARM,    4'd15, 32'd0,          1'b1, 16'h0000},
      '{OP_ARM,    4'd7,  32'hFFFF_FFFF,  1'b1, 16'h0000},
      '{OP_TICK,   4'd15, 32'hFFFF_FFFF,  1'b1, 16'h8001},
      '{OP_ARM,    4'd5,  32'd1,          1'b1, 16'h0000},
      '{OP_ARM,    4'd5,  32'd3,          1'b1, 16'h0000},
      '{OP_TICK,   4'd0,  32'd0,          1'b0, 16'h0000},
      '{OP_ARM,    4'd9,  32'd0,          1'b0, 16'h0000},
      '{OP_DISARM, 4'd9,  32'd0,          1'b0, 16'h0000},
      '{OP_TICK,   4'd0,  32'd0,          1'b0, 16'h0000},
      '{OP_TICK,   4'd0,  32'd0,          1'b0, 16'h0000},
      '{OP_ARM,    4'd10, 32'h5555_5555,  1'b0, 16'h0000},
      '{OP_ARM,    4'd11, 32'hAAAA_AAAA,  1'b0, 16'h0000},
      '{OP_DISARM, 4'd7,  32'd0,          1'b0, 16'h0000},
      '{OP_ARM,    4'd1,  32'd1,          1'b0, 16'h0000},
      '{OP_ARM,    4'd2,  32'd0,          1'b0, 16'h0000},
      '{OP_TICK,   4'd0,  32'd0,          1'b0, 16'h0000},
      '{OP_DISARM, 4'd10, 32'd0,          1'b0, 16'h0000},
      '{OP_DISARM, 4'd11, 32'd0,          1'b0, 16'h0000},
      '{OP_ARM,    4'd6,  32'd2,          1'b0, 16'h0000},
      '{OP_TICK,   4'd0,  32'd0,          1'b0, 16'h0000},
      '{OP_TICK,   4'd0,  32'd0,          1'b0, 16'h0000}
   };

   logic clock;
   logic reset;

   dtt_req_if req_if ();
   dtt_rsp_if rsp_if ();

   deadline_trigger_table_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   logic [TIME_W-1:0] trig_now;
   logic [TIME_W-1:0] trig_deadline [SLOTS];
   logic [SLOTS-1:0]  trig_armed;

   fire_type pending_fires [$];
   fire_type expected_fire;
   int       mismatches;
   int       sent_count;
   int       stall_cycles;
   int       tx_idle_pct;
   int       rx_idle_pct;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic logic [SLOTS-1:0] update_triggers(input logic [OP_W-1:0] op,
                                                        input logic [SLOT_W-1:0] slot,
                                                        input logic [DELAY_W-1:0] delay);
      logic [SLOTS-1:0] fired;
      fired = '0;
      unique case (op)
         OP_ARM: begin
            trig_deadline[slot] = trig_now + TIME_W'(delay);
            trig_armed[slot]    = 1'b1;
         end
         OP_DISARM: begin
            trig_armed[slot] = 1'b0;
         end
         OP_TICK: begin
            trig_now = trig_now + 1'b1;
            for (int s = 0; s < SLOTS; s++) begin
               if (trig_armed[s] && trig_deadline[s] <= trig_now) begin
                  trig_armed[s] = 1'b0;
                  fired[s]      = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return fired;
   endfunction

   function automatic void queue_fires(input logic [SLOTS-1:0] mask);
      fire_type f;
      int       last_slot;
      last_slot = -1;
      for (int s = 0; s < SLOTS; s++)
         if (mask[s]) last_slot = s;
      for (int s = 0; s < SLOTS; s++) begin
         if (mask[s]) begin
            f.slot = SLOT_W'(s);
            f.last = (s == last_slot);
            pending_fires = {pending_fires, f};
         end
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // entered and left at a falling edge
   task automatic send_cmd(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                           input logic [DELAY_W-1:0] delay, input logic typed = 1'b0,
                           input logic [SLOTS-1:0] typed_fires = '0);
      logic [SLOTS-1:0] fired;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.opcode      <= op;
      req_if.slot_index  <= slot;
      req_if.delay_ticks <= delay;
      do @(posedge clock); while (!req_if.ready);
      fired = update_triggers(op, slot, delay);
      queue_fires(typed ? typed_fires : fired);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic random_sequence();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
         // short arm burst with near deadlines, an occasional disarm, then ticks
         repeat ($urandom_range(1, 6))
            send_cmd(OP_ARM, SLOT_W'($urandom_range(0, SLOTS-1)),
                     DELAY_W'($urandom_range(0, 6)));
         if ($urandom_range(0, 3) == 0)
            send_cmd(OP_DISARM, SLOT_W'($urandom_range(0, SLOTS-1)), $urandom);
         repeat ($urandom_range(1, 7))
            send_cmd(OP_TICK, SLOT_W'($urandom), $urandom);
      end else if (kind < 7) begin
         // fill the whole table so one tick fires many slots
         for (int s = 0; s < SLOTS; s++)
            send_cmd(OP_ARM, SLOT_W'(s), DELAY_W'($urandom_range(0, 3) == 0));
         repeat ($urandom_range(1, 3))
            send_cmd(OP_TICK, SLOT_W'($urandom), $urandom);
      end else begin
         repeat ($urandom_range(1, 8))
            send_cmd(OP_W'($urandom_range(0, 3)), SLOT_W'($urandom),
                     $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20));
      end
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_fires.size() == 0) begin
            report_mismatch($sformatf("unexpected fire of slot %0d", rsp_if.fired_slot));
         end else begin
            expected_fire = pending_fires.pop_front();
            if (rsp_if.fired_slot !== expected_fire.slot)
               report_mismatch($sformatf("fired_slot %0d, expected %0d",
                                         rsp_if.fired_slot, expected_fire.slot));
            if (rsp_if.last_fired !== expected_fire.last)
               report_mismatch($sformatf("last_fired %0b on slot %0d, expected %0b",
                                         rsp_if.last_fired, expected_fire.slot,
                                         expected_fire.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.opcode      = OP_ARM;
      req_if.slot_index  = '0;
      req_if.delay_ticks = '0;
      rsp_if.ready       = 1'b0;
      trig_now           = '0;
      trig_armed         = '0;
      mismatches         = 0;
      sent_count         = 0;
      stall_cycles       = 0;
      tx_idle_pct        = 10;
      rx_idle_pct        = 73;
      for (int s = 0; s < SLOTS; s++) trig_deadline[s] = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < N_DIRECTED; r++)
         send_cmd(DIRECTED[r].op, DIRECTED[r].slot, DIRECTED[r].delay,
                  DIRECTED[r].typed, DIRECTED[r].fires);

      while (sent_count < 160) random_sequence();
      tx_idle_pct = 73;
      rx_idle_pct = 10;
      while (sent_count < 320) random_sequence();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      while (sent_count < 470) random_sequence();
      req_if.valid <= 1'b0;

      while (pending_fires.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0 && pending_fires.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/dtt_pkg.sv
rtl/dtt_req_if.sv
rtl/dtt_rsp_if.sv
rtl/dtt_ram.sv
rtl/dtt_queue.sv
rtl/dtt_front.sv
rtl/dtt_back.sv
rtl/deadline_trigger_table_core.sv
verif/tb_deadline_trigger_table_core.sv
